/* sv/ppi_pkg.sv */
`default_nettype none

package ppi_pkg;

  localparam int SLOT_W      = 6;
  localparam int DT_W        = 17;
  localparam int FRAC_W      = 16;
  localparam int LIFE_W      = 31;
  localparam int MAX_REPORTS = 64;
  localparam int RPT_W       = $clog2(MAX_REPORTS + 1);

  localparam logic signed [31:0] ACCEL_BASE = 32'sd380764;
  localparam logic signed [31:0] FRAC_ONE   = 32'sd65536;
  localparam logic signed [31:0] SAT_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN    = 32'sh8000_0000;

  typedef enum logic [1:0] {
    K_REPORT = 2'd0,
    K_SPAWN  = 2'd1,
    K_FULL   = 2'd2
  } ppi_kind_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_SPAWN = 1'b1
  } ppi_op_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] acc;
    logic        [31:0] life;
    logic        [31:0] elap;
  } ppi_rec_t;

  typedef struct packed {
    logic signed [31:0] mul_a;
    logic [DT_W-1:0]    mul_b;
    logic               mul_en;
  } ppi_mul_req_t;

endpackage

`default_nettype wire

/* sv/ppi_mul.sv */
`default_nettype none

module ppi_mul import ppi_pkg::*; (
  input  wire                      clk,
  input  wire ppi_mul_req_t        req,
  input  wire logic signed [31:0]  addend,
  output logic signed [32:0]       quo,
  output logic signed [31:0]       sum
);

  logic signed [48:0] prod_full;
  logic signed [48:0] prod_r;
  logic signed [33:0] acc_full;

  assign prod_full = req.mul_a * $signed({1'b0, req.mul_b});

  always_ff @(posedge clk) begin
    if (req.mul_en) begin
      prod_r <= prod_full;
    end
  end

  // floor of product / 2^16
  assign quo      = prod_r[48:16];
  assign acc_full = {{2{addend[31]}}, addend} + {quo[32], quo};

  always_comb begin
    if (acc_full > 34'sd2147483647) begin
      sum = SAT_MAX;
    end else if (acc_full < -34'sd2147483648) begin
      sum = SAT_MIN;
    end else begin
      sum = acc_full[31:0];
    end
  end

endmodule

`default_nettype wire

/* sv/particle_pool_integrator.sv */
// channel | dir | tdata (low bit up)                                   | tuser | tlast
// in_     | in  | dt, spawn_x, spawn_y, spawn_z, rand_vx, rand_vz,     | op    | -
//         |     | rand_accel, rand_life, min_life, max_life, pad       |       |
// out_    | out | slot, out_x, out_y, out_z, still_alive, pad          | kind  | last
//
// Spawn: S_SRCH steps over occupied slots, S_SPW claims the free one and S_SEMIT shows
// the result beat. Tick: S_RD skips dead slots; a survivor passes S_LOAD, S_MUL and
// S_ADD four times, S_WR, S_EMIT, an expiring one S_LOAD, S_EMIT; each report waits
// in S_EMIT until the beat ahead is taken. Four shared Q16.16 x dt products per survivor.
// Synchronous active-low reset clears every alive flag; the stores need no clearing.
// in_tready is high only while idle; a stalled out_ beat holds the sequencer.
`default_nettype none

module particle_pool_integrator import ppi_pkg::*; #(
  parameter int PARTICLES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [239:0]  in_tdata,  // dt, spawn_x, spawn_y, spawn_z, rand_vx, rand_vz,
                                        // rand_accel, rand_life, min_life, max_life, 0
  input  wire logic          in_tuser,  // op
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [103:0]       out_tdata, // slot, out_x, out_y, out_z, still_alive, 0
  output logic [1:0]         out_tuser, // kind
  output logic               out_tlast  // last
);

  localparam int IW = $clog2(PARTICLES);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_SRCH  = 12'b0000_0000_0010,
    S_SPW   = 12'b0000_0000_0100,
    S_SEMIT = 12'b0000_0000_1000,
    S_FULL  = 12'b0000_0001_0000,
    S_RD    = 12'b0000_0010_0000,
    S_LOAD  = 12'b0000_0100_0000,
    S_MUL   = 12'b0000_1000_0000,
    S_ADD   = 12'b0001_0000_0000,
    S_WR    = 12'b0010_0000_0000,
    S_EMIT  = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } ppi_state_t;

  ppi_state_t state_r, state_nxt;

  logic [DT_W-1:0]           dt_r;
  logic signed [31:0]        sx_r, sy_r, sz_r;
  logic [FRAC_W-1:0]         rvx_r, rvz_r, racc_r, rlife_r;
  logic [LIFE_W-1:0]         lo_r, hi_r;

  logic [IW-1:0]             idx_r;
  logic [PARTICLES-1:0]      alive_r;
  logic [1:0]                k_r;
  logic                      dies_r;
  logic [RPT_W-1:0]          n_r;
  logic                      pend_r;

  ppi_rec_t                  mem [PARTICLES];
  ppi_rec_t                  rd_r;
  ppi_rec_t                  w_r;
  ppi_rec_t                  spawn_rec;
  ppi_rec_t                  load_rec;
  logic                      mem_we;
  ppi_rec_t                  mem_wdata;

  logic                      out_valid_r;
  ppi_kind_t                 out_kind_r;
  logic [SLOT_W-1:0]         out_slot_r;
  logic signed [31:0]        out_x_r, out_y_r, out_z_r;
  logic                      out_alive_r;
  logic                      out_last_r;

  ppi_mul_req_t              mreq;
  logic signed [31:0]        addend;
  logic signed [32:0]        quo;
  logic signed [31:0]        sum;

  logic                      in_acc;
  logic                      idx_last;
  logic                      cur_alive;
  logic [LIFE_W-1:0]         span;
  logic [32:0]               esum;
  logic [31:0]               esat;
  logic                      edies;
  logic [IW+SLOT_W-1:0]      idx_ext;
  logic [SLOT_W-1:0]         cur_slot;
  logic                      rpt_full;
  logic                      emit_go;
  logic                      emit_load;
  logic                      emit_flush;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign idx_last   = (idx_r == IW'(PARTICLES - 1));
  assign cur_alive  = alive_r[idx_r];
  assign span       = (hi_r > lo_r) ? (hi_r - lo_r) : '0;
  assign esum       = {1'b0, rd_r.elap} + 33'(dt_r);
  assign esat       = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
  assign edies      = (esat >= rd_r.life);
  assign idx_ext    = {{SLOT_W{1'b0}}, idx_r};
  assign cur_slot   = idx_ext[SLOT_W-1:0];
  assign rpt_full   = (n_r == RPT_W'(MAX_REPORTS));
  assign emit_load  = !rpt_full && !out_valid_r && !pend_r;
  assign emit_flush = !rpt_full && !out_valid_r && pend_r;
  assign emit_go    = rpt_full || emit_load;

  // shared multiplier operands
  always_comb begin
    mreq.mul_a  = '0;
    mreq.mul_b  = dt_r;
    mreq.mul_en = 1'b0;
    addend      = w_r.vy;
    case (state_r)
      S_SRCH: begin
        mreq.mul_a  = $signed({1'b0, span});
        mreq.mul_b  = {1'b0, rlife_r};
        mreq.mul_en = !cur_alive;
      end
      S_MUL: begin
        mreq.mul_en = 1'b1;
        case (k_r)
          2'd0:    mreq.mul_a = w_r.acc;
          2'd1:    mreq.mul_a = w_r.vx;
          2'd2:    mreq.mul_a = w_r.vy;
          default: mreq.mul_a = w_r.vz;
        endcase
      end
      default: begin
      end
    endcase
    case (k_r)
      2'd0:    addend = w_r.vy;
      2'd1:    addend = w_r.px;
      2'd2:    addend = w_r.py;
      default: addend = w_r.pz;
    endcase
  end

  ppi_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .addend (addend),
    .quo    (quo),
    .sum    (sum)
  );

  always_comb begin
    load_rec      = rd_r;
    load_rec.elap = esat;
  end

  always_comb begin
    spawn_rec.px   = sx_r;
    spawn_rec.py   = sy_r;
    spawn_rec.pz   = sz_r;
    spawn_rec.vx   = $signed({15'b0, rvx_r, 1'b0}) - FRAC_ONE;
    spawn_rec.vy   = '0;
    spawn_rec.vz   = $signed({15'b0, rvz_r, 1'b0}) - FRAC_ONE;
    spawn_rec.acc  = ACCEL_BASE + $signed({15'b0, racc_r, 1'b0});
    spawn_rec.life = 32'({2'b0, lo_r} + quo);
    spawn_rec.elap = '0;
    mem_we         = 1'b0;
    mem_wdata      = w_r;
    unique case (state_r)
      S_SPW: begin
        mem_we    = 1'b1;
        mem_wdata = spawn_rec;
      end
      S_WR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= mem_wdata;
    end
    rd_r <= mem[idx_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = (ppi_op_t'(in_tuser) == OP_SPAWN) ? S_SRCH : S_RD;
      S_SRCH: begin
        if (!cur_alive) begin
          state_nxt = S_SPW;
        end else if (idx_last) begin
          state_nxt = S_FULL;
        end
      end
      S_SPW:   state_nxt = S_SEMIT;
      S_SEMIT: if (!out_valid_r) state_nxt = S_IDLE;
      S_FULL:  if (!out_valid_r) state_nxt = S_IDLE;
      S_RD: begin
        if (cur_alive) begin
          state_nxt = S_LOAD;
        end else if (idx_last) begin
          state_nxt = S_FIN;
        end
      end
      S_LOAD:  state_nxt = edies ? S_EMIT : S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = (k_r == 2'd3) ? S_WR : S_MUL;
      S_WR:    state_nxt = S_EMIT;
      S_EMIT:  if (emit_go) state_nxt = idx_last ? S_FIN : S_RD;
      S_FIN:   if (!out_valid_r && !pend_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alive_r     <= '0;
      idx_r       <= '0;
      n_r         <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r) inside
        S_IDLE: begin
          if (in_acc) begin
            idx_r <= '0;
            n_r   <= '0;
          end
        end
        S_SRCH: if (cur_alive && !idx_last) idx_r <= idx_r + 1'b1;
        S_SPW:  alive_r[idx_r] <= 1'b1;
        S_SEMIT, S_FULL: if (!out_valid_r) out_valid_r <= 1'b1;
        S_RD:   if (!cur_alive && !idx_last) idx_r <= idx_r + 1'b1;
        S_LOAD: if (edies) alive_r[idx_r] <= 1'b0;
        S_EMIT: begin
          if (emit_flush) begin
            out_valid_r <= 1'b1;
            pend_r      <= 1'b0;
          end else if (emit_load) begin
            n_r <= n_r + 1'b1;
            if (n_r == RPT_W'(MAX_REPORTS - 1)) begin
              out_valid_r <= 1'b1;
            end else begin
              pend_r <= 1'b1;
            end
          end
          if (emit_go && !idx_last) idx_r <= idx_r + 1'b1;
        end
        S_FIN: begin
          if (!out_valid_r && pend_r) begin
            out_valid_r <= 1'b1;
            pend_r      <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt_r    <= in_tdata[16:0];
      sx_r    <= in_tdata[48:17];
      sy_r    <= in_tdata[80:49];
      sz_r    <= in_tdata[112:81];
      rvx_r   <= in_tdata[128:113];
      rvz_r   <= in_tdata[144:129];
      racc_r  <= in_tdata[160:145];
      rlife_r <= in_tdata[176:161];
      lo_r    <= in_tdata[207:177];
      hi_r    <= in_tdata[238:208];
    end
    case (state_r)
      S_LOAD: begin
        w_r      <= load_rec;
        dies_r   <= edies;
        k_r      <= 2'd0;
      end
      S_ADD: begin
        case (k_r)
          2'd0:    w_r.vy <= sum;
          2'd1:    w_r.px <= sum;
          2'd2:    w_r.py <= sum;
          default: w_r.pz <= sum;
        endcase
        k_r <= k_r + 1'b1;
      end
      S_SEMIT: begin
        if (!out_valid_r) begin
          out_kind_r  <= K_SPAWN;
          out_slot_r  <= cur_slot;
          out_x_r     <= sx_r;
          out_y_r     <= sy_r;
          out_z_r     <= sz_r;
          out_alive_r <= 1'b1;
          out_last_r  <= 1'b1;
        end
      end
      S_FULL: begin
        if (!out_valid_r) begin
          out_kind_r  <= K_FULL;
          out_slot_r  <= '0;
          out_x_r     <= '0;
          out_y_r     <= '0;
          out_z_r     <= '0;
          out_alive_r <= 1'b0;
          out_last_r  <= 1'b1;
        end
      end
      S_EMIT: begin
        if (emit_load) begin
          out_kind_r  <= K_REPORT;
          out_slot_r  <= cur_slot;
          out_x_r     <= w_r.px;
          out_y_r     <= w_r.py;
          out_z_r     <= w_r.pz;
          out_alive_r <= !dies_r;
          out_last_r  <= (n_r == RPT_W'(MAX_REPORTS - 1));
        end
      end
      S_FIN: begin
        if (!out_valid_r && pend_r) begin
          out_last_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_alive_r, out_z_r, out_y_r, out_x_r, out_slot_r};

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r)
    else $error("report still held back while idle");

  a_pending_not_shown: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !out_valid_r)
    else $error("held-back report overlaps a shown beat");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FULL) |-> (&alive_r))
    else $error("pool full reported with a free slot");

  a_claimed_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPW) |=> (state_r == S_SEMIT) && alive_r[idx_r])
    else $error("claimed slot not marked alive");

  a_report_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RPT_W'(MAX_REPORTS))
    else $error("report count beyond limit");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
module testbench;
  import ppi_pkg::*;

  localparam int          PARTICLES = 64;
  localparam int unsigned LIMIT     = 1_000_000;
  localparam int          SETTLE    = 1000;

  typedef struct packed {
    ppi_op_t            op;
    logic [DT_W-1:0]    dt;
    logic signed [31:0] spawn_x;
    logic signed [31:0] spawn_y;
    logic signed [31:0] spawn_z;
    logic [15:0]        rand_vx;
    logic [15:0]        rand_vz;
    logic [15:0]        rand_accel;
    logic [15:0]        rand_life;
    logic [LIFE_W-1:0]  min_life;
    logic [LIFE_W-1:0]  max_life;
    logic               drain;
  } pool_item_t;

  typedef struct packed {
    ppi_kind_t          kind;
    logic [SLOT_W-1:0]  slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               alive;
    logic               last;
  } report_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [239:0] in_tdata   = '0;  // dt, spawn_x, spawn_y, spawn_z, rand_vx, rand_vz,
                                  // rand_accel, rand_life, min_life, max_life, 0
  logic         in_tuser   = 1'b0; // op
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;        // slot, out_x, out_y, out_z, still_alive, 0
  logic [1:0]   out_tuser;        // kind
  logic         out_tlast;

  particle_pool_integrator #(.PARTICLES(PARTICLES)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // shadow of the pool
  logic               live_flag [PARTICLES];
  logic signed [31:0] pos_x [PARTICLES];
  logic signed [31:0] pos_y [PARTICLES];
  logic signed [31:0] pos_z [PARTICLES];
  logic signed [31:0] vel_x [PARTICLES];
  logic signed [31:0] vel_y [PARTICLES];
  logic signed [31:0] vel_z [PARTICLES];
  logic signed [31:0] lift  [PARTICLES];
  logic        [31:0] life  [PARTICLES];
  logic        [31:0] elap  [PARTICLES];

  pool_item_t item_q[$];
  report_t    report_q[$];

  int unsigned cycles;
  int          errors;
  int          n_spawn_items, n_tick_items;
  int          n_claims, n_full, n_reports, n_expired;

  pool_item_t  cur_item;
  logic        drv_have;
  int          drv_gap;
  logic        drv_burst;
  int          mon_stall;
  logic        mon_burst;
  logic        mon_ready;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > longint'(SAT_MAX)) return SAT_MAX;
    if (v < longint'(SAT_MIN)) return SAT_MIN;
    return v[31:0];
  endfunction

  // floor(a * dt / 2^16)
  function automatic longint scale_dt(logic signed [31:0] a, logic [DT_W-1:0] dt);
    longint p;
    p = longint'(a) * longint'(dt);
    return p >>> 16;
  endfunction

  task automatic advance_pool(pool_item_t it);
    int      slot;
    int      last_live;
    longint  span;
    longint  e;
    logic    lives;
    report_t r;
    if (it.op == OP_SPAWN) begin
      slot = -1;
      for (int i = 0; i < PARTICLES; i++)
        if (slot < 0 && !live_flag[i]) slot = i;
      if (slot < 0) begin
        r = '{kind: K_FULL, slot: '0, x: '0, y: '0, z: '0, alive: 1'b0, last: 1'b1};
      end else begin
        span = (it.max_life > it.min_life) ? longint'(it.max_life) - longint'(it.min_life) : 0;
        pos_x[slot] = it.spawn_x;
        pos_y[slot] = it.spawn_y;
        pos_z[slot] = it.spawn_z;
        vel_x[slot] = 2 * int'(it.rand_vx) - FRAC_ONE;
        vel_y[slot] = '0;
        vel_z[slot] = 2 * int'(it.rand_vz) - FRAC_ONE;
        lift[slot]  = ACCEL_BASE + 2 * int'(it.rand_accel);
        life[slot]  = 32'(longint'(it.min_life) + ((longint'(it.rand_life) * span) >> 16));
        elap[slot]  = '0;
        live_flag[slot] = 1'b1;
        r = '{kind: K_SPAWN, slot: slot[SLOT_W-1:0], x: it.spawn_x, y: it.spawn_y,
              z: it.spawn_z, alive: 1'b1, last: 1'b1};
      end
      report_q = {report_q, r};
    end else begin
      last_live = -1;
      for (int i = 0; i < PARTICLES; i++)
        if (live_flag[i]) last_live = i;
      for (int i = 0; i < PARTICLES; i++) begin
        if (live_flag[i]) begin
          e = longint'(elap[i]) + longint'(it.dt);
          elap[i] = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
          if (elap[i] >= life[i]) begin
            live_flag[i] = 1'b0;
            lives = 1'b0;
          end else begin
            vel_y[i] = clamp32(longint'(vel_y[i]) + scale_dt(lift[i], it.dt));
            pos_x[i] = clamp32(longint'(pos_x[i]) + scale_dt(vel_x[i], it.dt));
            pos_y[i] = clamp32(longint'(pos_y[i]) + scale_dt(vel_y[i], it.dt));
            pos_z[i] = clamp32(longint'(pos_z[i]) + scale_dt(vel_z[i], it.dt));
            lives = 1'b1;
          end
          r = '{kind: K_REPORT, slot: i[SLOT_W-1:0], x: pos_x[i], y: pos_y[i],
                z: pos_z[i], alive: lives, last: (i == last_live)};
          report_q = {report_q, r};
        end
      end
    end
  endtask

  function automatic pool_item_t make_tick();
    pool_item_t it;
    int unsigned sel;
    it = '0;
    it.op = OP_TICK;
    sel = $urandom_range(0, 7);
    if (sel == 0) it.dt = '0;
    else if (sel == 1) it.dt = $urandom;
    else it.dt = $urandom_range(0, 65536);
    it.spawn_x = $urandom;
    it.spawn_y = $urandom;
    it.spawn_z = $urandom;
    it.rand_vx = $urandom;
    it.rand_vz = $urandom;
    it.rand_accel = $urandom;
    it.rand_life = $urandom;
    it.min_life = $urandom;
    it.max_life = $urandom;
    return it;
  endfunction

  function automatic pool_item_t make_spawn(int unsigned life_cap);
    pool_item_t it;
    it = make_tick();
    it.op = OP_SPAWN;
    if ($urandom_range(0, 1) == 0) begin
      it.spawn_x = $urandom_range(0, 2 ** 22) - 2 ** 21;
      it.spawn_y = $urandom_range(0, 2 ** 22) - 2 ** 21;
      it.spawn_z = $urandom_range(0, 2 ** 22) - 2 ** 21;
    end
    if ($urandom_range(0, 15) != 0) begin
      it.min_life = $urandom_range(0, life_cap);
      it.max_life = $urandom_range(0, 2 * life_cap);
    end
    return it;
  endfunction

  function automatic pool_item_t make_spawn_fixed(
    logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
    logic [15:0] rvx, logic [15:0] rvz, logic [15:0] racc, logic [15:0] rlife,
    logic [LIFE_W-1:0] lo, logic [LIFE_W-1:0] hi);
    pool_item_t it;
    it = '0;
    it.op = OP_SPAWN;
    it.spawn_x = x;
    it.spawn_y = y;
    it.spawn_z = z;
    it.rand_vx = rvx;
    it.rand_vz = rvz;
    it.rand_accel = racc;
    it.rand_life = rlife;
    it.min_life = lo;
    it.max_life = hi;
    return it;
  endfunction

  function automatic pool_item_t make_tick_fixed(logic [DT_W-1:0] dt);
    pool_item_t it;
    it = '0;
    it.op = OP_TICK;
    it.dt = dt;
    return it;
  endfunction

  function automatic int draw_wait(logic burst);
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("particle_pool_integrator test failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_have = 1'b0;
      drv_gap  = 0;
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_pool(cur_item);
        if (cur_item.op == OP_SPAWN) n_spawn_items++;
        else n_tick_items++;
        drv_have = 1'b0;
        if ($urandom_range(0, 15) == 0) drv_burst = ~drv_burst;
        drv_gap = draw_wait(drv_burst);
      end
      if (!drv_have) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (item_q.size() > 0 && (!item_q[0].drain || report_q.size() == 0)) begin
          cur_item = item_q.pop_front();
          drv_have = 1'b1;
          in_tdata <= {1'b0, cur_item.max_life, cur_item.min_life, cur_item.rand_life,
                       cur_item.rand_accel, cur_item.rand_vz, cur_item.rand_vx,
                       cur_item.spawn_z, cur_item.spawn_y, cur_item.spawn_x, cur_item.dt};
          in_tuser <= cur_item.op;
        end
      end
      in_tvalid <= drv_have;
    end
  end

  // monitor
  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      mon_stall = 0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        case (out_tuser)
          K_SPAWN:  n_claims++;
          K_FULL:   n_full++;
          default: begin
            n_reports++;
            if (!out_tdata[102]) n_expired++;
          end
        endcase
        if (report_q.size() == 0) begin
          $error("result beat with no expectation waiting: kind %0d slot %0d",
                 out_tuser, out_tdata[5:0]);
          errors++;
        end else begin
          want = report_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_tuser));
          check_field("slot", 32'(want.slot), 32'(out_tdata[5:0]));
          check_field("out_x", want.x, out_tdata[37:6]);
          check_field("out_y", want.y, out_tdata[69:38]);
          check_field("out_z", want.z, out_tdata[101:70]);
          check_field("still_alive", 32'(want.alive), 32'(out_tdata[102]));
          check_field("last", 32'(want.last), 32'(out_tlast));
        end
        if ($urandom_range(0, 15) == 0) mon_burst = ~mon_burst;
        mon_stall = draw_wait(mon_burst);
      end
      if (mon_stall > 0) begin
        mon_stall--;
        mon_ready = 1'b0;
      end else begin
        mon_ready = 1'b1;
      end
      out_tready <= mon_ready;
    end
  end

  initial begin
    pool_item_t it;
    cycles = 0;
    errors = 0;
    drv_burst = 1'b0;
    mon_burst = 1'b0;
    for (int i = 0; i < PARTICLES; i++) live_flag[i] = 1'b0;

    // directed: empty tick, extreme spawns, zero and reversed lifetimes, dt extremes
    item_q = {item_q, make_tick_fixed(17'd65536)};
    item_q = {item_q, make_spawn_fixed(SAT_MAX, SAT_MIN, 32'sd0, 16'hFFFF, 16'h0000,
                                       16'hFFFF, 16'hFFFF, '0, 31'h7FFF_FFFF)};
    item_q = {item_q, make_spawn_fixed(SAT_MIN, SAT_MAX, -32'sd1, 16'h0000, 16'hFFFF,
                                       16'h0000, 16'h0000, 31'h7FFF_FFFF, '0)};
    item_q = {item_q, make_spawn_fixed(32'sd65536, -32'sd65536, 32'sd12345, 16'h8000,
                                       16'h8000, 16'h8000, 16'h8000, 31'd65536, 31'd65536)};
    item_q = {item_q, make_spawn_fixed(32'sd0, 32'sd0, 32'sd0, 16'h1234, 16'hABCD,
                                       16'h5555, 16'hAAAA, '0, '0)};
    item_q = {item_q, make_tick_fixed('0)};
    item_q = {item_q, make_tick_fixed('1)};
    item_q = {item_q, make_spawn_fixed(-32'sd1000, 32'sd1000, SAT_MAX, 16'hAAAA, 16'h5555,
                                       16'hFFFF, 16'h0001, 31'd131072, 31'd262144)};
    item_q = {item_q, make_tick_fixed(17'd1)};
    item_q = {item_q, make_tick_fixed(17'd65536)};
    item_q = {item_q, make_tick_fixed(17'd32768)};
    item_q = {item_q, make_spawn_fixed(SAT_MIN, SAT_MIN, SAT_MIN, 16'h0000, 16'h0000,
                                       16'h0000, 16'hFFFF, 31'd1, 31'd0)};
    item_q = {item_q, make_tick_fixed(17'd65536)};
    item_q = {item_q, make_tick_fixed('1)};

    // mixed traffic
    for (int n = 0; n < 45; n++) begin
      it = ($urandom_range(0, 9) < 6) ? make_spawn(262144) : make_tick();
      it.drain = (n == 30);
      item_q = {item_q, it};
    end

    // fill the pool past capacity, then tick it down
    for (int n = 0; n < 70; n++) begin
      it = make_spawn(131072);
      it.drain = (n == 0);
      item_q = {item_q, it};
    end
    for (int n = 0; n < 12; n++) item_q = {item_q, make_tick()};

    for (int n = 0; n < 30; n++) begin
      it = ($urandom_range(0, 1) == 0) ? make_spawn(196608) : make_tick();
      it.drain = (n == 15);
      item_q = {item_q, it};
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (item_q.size() > 0 || in_tvalid || report_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d spawns and %0d ticks; saw %0d claims, %0d pool-full flags,",
             n_spawn_items, n_tick_items, n_claims, n_full);
    $display("and %0d particle reports of which %0d were expiries.", n_reports, n_expired);
    if (errors == 0 && report_q.size() == 0) begin
      $display("particle_pool_integrator test passed");
    end else begin
      $display("particle_pool_integrator test failed");
    end
    $finish;
  end

endmodule
